// ===== rtl/bmp_pixel_stream_decoder_top_macros.svh =====
// Assertion macros used by the bitmap pixel decoder back end.
// Included by bmp_psd_back, which checks its own logic; needs nothing else.
`ifndef BMP_PIXEL_STREAM_DECODER_TOP_MACROS_SVH
`define BMP_PIXEL_STREAM_DECODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmp_psd_pkg.sv =====
// Types and constants of the bitmap pixel stream decoder.
// Used by the front, queue, back and top level; depends on nothing.
package bmp_psd_pkg;

    localparam int unsigned SIDE_W      = 14;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned MAX_SIDE    = 8192;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    localparam logic [23:0] MAGENTA = 24'hFF00FF;

    // pixel format register codes
    localparam logic [2:0] FMT_BPP1 = 3'd0;
    localparam logic [2:0] FMT_BPP2 = 3'd1;
    localparam logic [2:0] FMT_BPP4 = 3'd2;
    localparam logic [2:0] FMT_BPP8 = 3'd3;
    localparam logic [2:0] FMT_BGR  = 3'd4;
    localparam logic [2:0] FMT_BGRX = 3'd5;

    // log2 of bits per palette index
    localparam logic [1:0] LBPP_1 = 2'd0;
    localparam logic [1:0] LBPP_2 = 2'd1;
    localparam logic [1:0] LBPP_4 = 2'd2;
    localparam logic [1:0] LBPP_8 = 2'd3;

    // register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        CMD_PAL_WRITE,
        CMD_PAL_PIXELS,
        CMD_DIRECT
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0]        fmt;
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [1:0]        lbpp;
        logic [7:0]        data;
        logic [2:0]        cnt_m1;
        logic [SIDE_W-1:0] col;
        logic [SIDE_W-1:0] row;
        logic              last_row;
        logic [23:0]       rgb;
    } t_cmd;

endpackage

// ===== rtl/bmp_psd_in_if.sv =====
// Input channel of the bitmap pixel decoder: palette writes and pixel bytes.
// Valid/ready handshake; no dependencies.
interface bmp_psd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;

    modport source (
        output valid, mode, data_byte, palette_index, palette_red, palette_green,
               palette_blue,
        input  ready
    );
    modport sink (
        input  valid, mode, data_byte, palette_index, palette_red, palette_green,
               palette_blue,
        output ready
    );
endinterface

// ===== rtl/bmp_psd_out_if.sv =====
// Output channel of the bitmap pixel decoder: one RGB pixel per transfer.
// Valid/ready handshake; no dependencies.
interface bmp_psd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [12:0] pixel_column;
    logic [12:0] pixel_row;
    logic        run_last;
    logic        frame_last;

    modport source (
        output valid, red_out, green_out, blue_out, pixel_column, pixel_row, run_last,
               frame_last,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, pixel_column, pixel_row, run_last,
               frame_last,
        output ready
    );
endinterface

// ===== rtl/bmp_psd_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module bmp_psd_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bmp_psd_front.sv =====
// Front end: takes input requests, tracks row and pixel position; palette writes and
// requests with pixels become back-end commands. Uses bmp_psd_pkg, bmp_psd_in_if.
module bmp_psd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmp_psd_pkg::t_cfg i_cfg,
    bmp_psd_in_if.sink        i_pix,
    input  logic              i_full,
    output logic              o_push,
    output bmp_psd_pkg::t_cmd o_cmd
);
    import bmp_psd_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [SIDE_W-1:0] r_rpd, n_rpd;
    logic [SIDE_W-1:0] r_rows, n_rows;
    logic [1:0]        r_phase, n_phase;
    logic [15:0]       r_pend, n_pend;

    logic              accept;
    logic [SIDE_W-1:0] rows_cur;
    logic [SIDE_W-1:0] row_idx;
    logic              last_row;
    logic              in_row;
    logic [SIDE_W-1:0] avail;
    logic [3:0]        per;
    logic [3:0]        pal_cnt;
    logic              is_pal_fmt;
    logic [2:0]        bpx;
    logic [SIDE_W+2:0] w_ext;
    logic [SIDE_W+2:0] data_bytes;
    logic [SIDE_W+2:0] stride_ext;
    logic [POS_W-1:0]  stride;
    logic [POS_W-1:0]  pos_inc;
    logic              end_row;
    logic              emit_direct;
    logic              has_pixels;

    assign i_pix.ready = !i_full;
    assign accept      = i_pix.valid && !i_full;

    always_comb begin
        rows_cur   = (r_rows >= i_cfg.height) ? '0 : r_rows;
        row_idx    = i_cfg.height - SIDE_W'(1) - rows_cur;
        last_row   = ({1'b0, rows_cur} + (SIDE_W+1)'(1)) == {1'b0, i_cfg.height};
        in_row     = r_rpd < i_cfg.width;
        avail      = in_row ? (i_cfg.width - r_rpd) : '0;
        per        = 4'd8 >> i_cfg.fmt[1:0];
        pal_cnt    = (avail > SIDE_W'(per)) ? per : avail[3:0];
        is_pal_fmt = i_cfg.fmt <= FMT_BPP8;
        bpx        = (i_cfg.fmt == FMT_BGR) ? 3'd3 : 3'd4;

        w_ext = (SIDE_W+3)'(i_cfg.width);
        unique case (i_cfg.fmt)
            FMT_BPP1: data_bytes = (w_ext + (SIDE_W+3)'(7)) >> 3;
            FMT_BPP2: data_bytes = (w_ext + (SIDE_W+3)'(3)) >> 2;
            FMT_BPP4: data_bytes = (w_ext + (SIDE_W+3)'(1)) >> 1;
            FMT_BPP8: data_bytes = w_ext;
            FMT_BGR:  data_bytes = w_ext + (w_ext << 1);
            default:  data_bytes = w_ext << 2;
        endcase
        // round up to a whole word
        stride_ext = (data_bytes + (SIDE_W+3)'(3)) & ~(SIDE_W+3)'(3);
        stride     = stride_ext[POS_W-1:0];
        pos_inc    = r_pos + POS_W'(1);
        end_row    = pos_inc >= stride;

        emit_direct = !is_pal_fmt && in_row && (r_phase == 2'd2);
        has_pixels  = is_pal_fmt ? (pal_cnt != 4'd0) : emit_direct;
    end

    always_comb begin
        n_pos   = r_pos;
        n_rpd   = r_rpd;
        n_rows  = r_rows;
        n_phase = r_phase;
        n_pend  = r_pend;
        if (accept && i_pix.mode) begin
            n_rows = rows_cur;
            n_pos  = pos_inc;
            if (is_pal_fmt) begin
                n_rpd = r_rpd + SIDE_W'(pal_cnt);
            end else if (in_row) begin
                unique case (r_phase)
                    2'd0:    n_pend[7:0]  = i_pix.data_byte;
                    2'd1:    n_pend[15:8] = i_pix.data_byte;
                    2'd2:    n_rpd        = r_rpd + SIDE_W'(1);
                    default: ;  // stray fourth byte: drop it
                endcase
                n_phase = (({1'b0, r_phase} + 3'd1) < bpx) ? (r_phase + 2'd1) : 2'd0;
            end
            if (end_row) begin
                n_pos   = '0;
                n_rpd   = '0;
                n_phase = '0;
                n_pend  = '0;
                n_rows  = (({1'b0, rows_cur} + (SIDE_W+1)'(1)) >= {1'b0, i_cfg.height}) ?
                          '0 : (rows_cur + SIDE_W'(1));
            end
        end
    end

    always_comb begin
        o_push       = accept && (!i_pix.mode || has_pixels);
        o_cmd.kind   = !i_pix.mode ? CMD_PAL_WRITE : (is_pal_fmt ? CMD_PAL_PIXELS : CMD_DIRECT);
        o_cmd.lbpp   = i_cfg.fmt[1:0];
        o_cmd.data   = i_pix.mode ? i_pix.data_byte : i_pix.palette_index;
        o_cmd.cnt_m1 = is_pal_fmt ? 3'(pal_cnt - 4'd1) : 3'd0;
        o_cmd.col    = r_rpd;
        o_cmd.row    = row_idx;
        o_cmd.last_row = last_row;
        o_cmd.rgb    = i_pix.mode ? {i_pix.data_byte, r_pend[15:8], r_pend[7:0]} :
                       {i_pix.palette_red, i_pix.palette_green, i_pix.palette_blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rpd   <= '0;
            r_rows  <= '0;
            r_phase <= '0;
            r_pend  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_rpd   <= n_rpd;
            r_rows  <= n_rows;
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end
endmodule

// ===== rtl/bmp_psd_queue.sv =====
// Short command queue between the front and back ends.
// Uses bmp_psd_pkg.
module bmp_psd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bmp_psd_pkg::t_cmd i_cmd,
    output logic              o_full,
    output logic              o_valid,
    output bmp_psd_pkg::t_cmd o_cmd,
    input  logic              i_pop
);
    import bmp_psd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = do_push ? (r_wr + 1'b1) : r_wr;
        n_rd    = do_pop ? (r_rd + 1'b1) : r_rd;
        n_count = r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

// ===== rtl/bmp_psd_back.sv =====
// Back end: palette writes and lookups per index, direct pixels, output register.
// Uses bmp_psd_pkg, bmp_psd_out_if, bmp_psd_ram and the assertion macros.
`include "bmp_pixel_stream_decoder_top_macros.svh"

module bmp_psd_back #(
    parameter  int PALETTE_ENTRIES = 256,
    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  bmp_psd_pkg::t_cmd              i_cmd,
    output logic                           o_pop,
    input  logic [bmp_psd_pkg::SIDE_W-1:0] i_width,
    bmp_psd_out_if.source                  o_pix
);
    import bmp_psd_pkg::*;

    logic [2:0]                 r_k;
    logic                       r_s2_valid;
    logic                       r_s2_direct;
    logic                       r_s2_hit;
    logic [23:0]                r_s2_rgb;
    logic [SIDE_W-1:0]          r_s2_col;
    logic [SIDE_W-1:0]          r_s2_row;
    logic                       r_s2_run_last;
    logic                       r_s2_frame_last;
    logic [PALETTE_ENTRIES-1:0] r_entry_valid;

    logic              advance;
    logic              fire;
    logic              is_wr;
    logic              is_pal;
    logic              is_dir;
    logic              pix_fire;
    logic              last_sub;
    logic [2:0]        amt;
    logic [7:0]        shifted;
    logic [7:0]        idx;
    logic              rd_in_range;
    logic              wr_in_range;
    logic              we;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [SIDE_W-1:0] col_k;
    logic              frame_last;
    logic [23:0]       ram_q;
    logic [23:0]       pix_rgb;

    always_comb begin
        advance  = !r_s2_valid || o_pix.ready;
        fire     = i_valid && advance;
        is_wr    = i_cmd.kind == CMD_PAL_WRITE;
        is_pal   = i_cmd.kind == CMD_PAL_PIXELS;
        is_dir   = i_cmd.kind == CMD_DIRECT;
        pix_fire = fire && (is_pal || is_dir);
        last_sub = r_k == i_cmd.cnt_m1;
        o_pop    = fire && (!is_pal || last_sub);

        // take indices most significant bits first
        amt     = 3'(r_k << i_cmd.lbpp);
        shifted = i_cmd.data << amt;
        unique case (i_cmd.lbpp)
            LBPP_1: idx = {7'd0, shifted[7]};
            LBPP_2: idx = {6'd0, shifted[7:6]};
            LBPP_4: idx = {4'd0, shifted[7:4]};
            LBPP_8: idx = shifted;
        endcase

        rd_in_range = {1'b0, idx} < 9'(PALETTE_ENTRIES);
        wr_in_range = {1'b0, i_cmd.data} < 9'(PALETTE_ENTRIES);
        raddr       = idx[AW-1:0];
        waddr       = i_cmd.data[AW-1:0];
        we          = fire && is_wr && wr_in_range;
        re          = fire && is_pal;

        col_k      = i_cmd.col + SIDE_W'(r_k);
        frame_last = i_cmd.last_row && (({1'b0, col_k} + (SIDE_W+1)'(1)) == {1'b0, i_width});
    end

    bmp_psd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.rgb),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid    <= 1'b0;
            r_k           <= '0;
            r_entry_valid <= '0;
        end else begin
            if (advance) begin
                r_s2_valid <= pix_fire;
            end
            if (fire && is_pal) begin
                r_k <= last_sub ? 3'd0 : (r_k + 3'd1);
            end
            if (we) begin
                r_entry_valid[waddr] <= 1'b1;
            end
        end
    end

    // hold the output stage while the sink stalls
    always_ff @(posedge i_clk) begin
        if (advance && pix_fire) begin
            r_s2_direct     <= is_dir;
            r_s2_hit        <= rd_in_range && r_entry_valid[raddr];
            r_s2_rgb        <= i_cmd.rgb;
            r_s2_col        <= col_k;
            r_s2_row        <= i_cmd.row;
            r_s2_run_last   <= is_dir || last_sub;
            r_s2_frame_last <= frame_last;
        end
    end

    always_comb begin
        if (r_s2_direct) begin
            pix_rgb = r_s2_rgb;
        end else if (r_s2_hit) begin
            pix_rgb = ram_q;
        end else begin
            pix_rgb = MAGENTA;
        end
        o_pix.valid        = r_s2_valid;
        o_pix.red_out      = pix_rgb[23:16];
        o_pix.green_out    = pix_rgb[15:8];
        o_pix.blue_out     = pix_rgb[7:0];
        o_pix.pixel_column = 13'(r_s2_col);
        o_pix.pixel_row    = 13'(r_s2_row);
        o_pix.run_last     = r_s2_run_last;
        o_pix.frame_last   = r_s2_frame_last;
    end

    `BMP_ASSERT_SAME(a_sub_idle, i_clk, i_rst_n, !(i_valid && is_pal), r_k == 3'd0, "sub-pixel count left over")
    `BMP_ASSERT_SAME(a_sub_bound, i_clk, i_rst_n, i_valid && is_pal, r_k <= i_cmd.cnt_m1, "sub-pixel count overrun")
    `BMP_ASSERT_SAME(a_frame_run, i_clk, i_rst_n, r_s2_valid && r_s2_frame_last, r_s2_run_last, "frame end inside a run")
    `BMP_ASSERT_NEXT(a_read_lands, i_clk, i_rst_n, re, r_s2_valid && !r_s2_direct, "palette read lost")
endmodule

// ===== rtl/bmp_pixel_stream_decoder_top.sv =====
// Top level of the bitmap pixel stream decoder: config registers, front end,
// command queue and back end. Uses bmp_psd_pkg, both channel interfaces, all submodules.
//
//   channel   dir  handshake          payload
//   i_pix     in   valid/ready        mode, data byte, palette index and color
//   o_pix     out  valid/ready        rgb, column, row, run_last, frame_last
//   apb       in   psel/penable       format, width, height registers
//
// One input request a cycle while the four-entry queue has room. The back end
// emits one pixel a cycle unless the output stalls; a 1/2/4 bpp byte holds it for
// up to 8/4/2 pixels, one index per palette read. Queue and output are registered.
// Synchronous reset clears the palette valid bits at once; no clearing pass.
// A stalled output holds the back end; the queue then fills and drops ready.
module bmp_pixel_stream_decoder_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmp_psd_in_if.sink  i_pix,
    bmp_psd_out_if.source o_pix,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmp_psd_pkg::*;

    logic [2:0]        r_format, n_format;
    logic [SIDE_W-1:0] r_width, n_width;
    logic [SIDE_W-1:0] r_height, n_height;

    logic cfg_we;
    t_cfg cfg;
    logic q_push;
    t_cmd q_in;
    logic q_full;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (32'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        n_format = r_format;
        n_width  = r_width;
        n_height = r_height;
        if (cfg_we) begin
            unique case (paddr[3:2])
                REG_FORMAT: n_format = pwdata[2:0];
                REG_WIDTH:  n_width  = pwdata[SIDE_W-1:0];
                REG_HEIGHT: n_height = pwdata[SIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_BGR;
            r_width  <= SIDE_W'(1);
            r_height <= SIDE_W'(1);
        end else begin
            r_format <= n_format;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FORMAT: prdata = 32'(r_format);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.fmt    = (r_format > FMT_BGRX) ? FMT_BGRX : r_format;
        cfg.width  = clamp_side(r_width);
        cfg.height = clamp_side(r_height);
    end

    bmp_psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    bmp_psd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    bmp_psd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .i_width (cfg.width),
        .o_pix   (o_pix)
    );
endmodule
